// ----- rtl/bvre_pkg.sv -----
// -----------------------------------------------------------------------------
// bvre_pkg
// Shared constants, operation codes, state and control types for the bit
// vector range engine.
// -----------------------------------------------------------------------------
package bvre_pkg;

	localparam int IDX_W     = 12;                 // bit index width
	localparam int LEN_W     = 13;                 // length / count / position width
	localparam int WORD_W    = 64;                 // stored word width
	localparam int BIT_SEL_W = 6;                  // bit within a word
	localparam int WIDX_W    = IDX_W - BIT_SEL_W;  // word index reachable by an index
	localparam int MAX_WORDS = 1 << WIDX_W;
	localparam int MODE_W    = 3;
	localparam int POP_W     = BIT_SEL_W + 1;

	localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
	localparam logic [LEN_W-1:0] POS_NONE  = 13'h1FFF;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE_BIT   = 3'd0,
		MODE_READ_BIT    = 3'd1,
		MODE_RANGE_WRITE = 3'd2,
		MODE_RANGE_COUNT = 3'd3,
		MODE_FIND_FIRST  = 3'd4,
		MODE_FIND_LAST   = 3'd5,
		MODE_CLEAR_ALL   = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // take the item in
		logic issue;   // read the current word, step on
		logic finish;  // write the result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_needed;  // item has a valid range to walk
		logic last_word;    // current word is the last of the range
		logic pipe_busy;    // words still in flight
		logic out_free;     // result register can take a new result
	} ctrl_sts_t;

endpackage

// ----- rtl/bvre_if.sv -----
// -----------------------------------------------------------------------------
// bvre_if
// Valid/ready channels for the bit vector range engine: command items in,
// result items out.
// -----------------------------------------------------------------------------
interface bvre_cmd_if import bvre_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  low_index;
	logic [IDX_W-1:0]  high_index;
	logic              bit_in;

	modport source (output valid, mode, low_index, high_index, bit_in, input ready);
	modport sink (input valid, mode, low_index, high_index, bit_in, output ready);
endinterface

interface bvre_rsp_if import bvre_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic                    bit_out;
	logic [LEN_W-1:0]        ones_count;
	logic signed [LEN_W-1:0] position;
	logic                    error;

	modport source (output valid, bit_out, ones_count, position, error, input ready);
	modport sink (input valid, bit_out, ones_count, position, error, output ready);
endinterface

// ----- rtl/bvre_ram.sv -----
// -----------------------------------------------------------------------------
// bvre_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module bvre_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/bvre_ctrl.sv -----
// -----------------------------------------------------------------------------
// bvre_ctrl
// Controller: takes an item, walks its words, drains the datapath pipe and
// hands the result to the output register.
// -----------------------------------------------------------------------------
module bvre_ctrl import bvre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = sts.walk_needed ? ST_WALK : ST_FINISH;
				end
			end
			ST_WALK: begin
				if (sts.last_word) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_ready  = 1'b0;
		ctl        = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ctl.load  = cmd_valid;
			end
			ST_WALK: begin
				ctl.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				ctl.finish = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/bvre_datapath.sv -----
// -----------------------------------------------------------------------------
// bvre_datapath
// Word store, range checks, two-stage word pipe (mask and write back, then
// count and search) and the result register.
// -----------------------------------------------------------------------------
module bvre_datapath import bvre_pkg::*; #(
	parameter int WORD_COUNT = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [LEN_W-1:0]        cfg_wr_data,
	input  logic [MODE_W-1:0]       cmd_mode,
	input  logic [IDX_W-1:0]        cmd_low_index,
	input  logic [IDX_W-1:0]        cmd_high_index,
	input  logic                    cmd_bit_in,
	input  logic                    rsp_ready,
	output logic                    rsp_valid,
	output logic                    rsp_bit_out,
	output logic [LEN_W-1:0]        rsp_ones_count,
	output logic signed [LEN_W-1:0] rsp_position,
	output logic                    rsp_error,
	input  ctrl_cmd_t               ctl,
	output ctrl_sts_t               sts
);

	// indices are 12 bits, so no more than MAX_WORDS words can ever be reached
	localparam int STORE_DEPTH = (WORD_COUNT < MAX_WORDS) ? WORD_COUNT : MAX_WORDS;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CAP_W       = LEN_W + 4;
	localparam logic [CAP_W-1:0] CAP_BITS = CAP_W'(WORD_COUNT * WORD_W);

	function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
		logic [3:0]       part [8];
		logic [POP_W-1:0] sum;
		sum = '0;
		for (int g = 0; g < 8; g++) begin
			part[g] = '0;
			for (int k = 0; k < 8; k++) begin
				part[g] = part[g] + 4'(x[g*8 + k]);
			end
		end
		for (int g = 0; g < 8; g++) begin
			sum = sum + POP_W'(part[g]);
		end
		return sum;
	endfunction

	function automatic logic [BIT_SEL_W-1:0] onehot_idx(input logic [WORD_W-1:0] oh);
		logic [BIT_SEL_W-1:0] idx;
		idx = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (oh[k]) begin
				idx = idx | BIT_SEL_W'(k);
			end
		end
		return idx;
	endfunction

	function automatic logic [WORD_W-1:0] rev64(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] r;
		for (int k = 0; k < WORD_W; k++) begin
			r[k] = x[WORD_W-1-k];
		end
		return r;
	endfunction

	// configuration
	logic [LEN_W-1:0] bit_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_length_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			bit_length_q <= cfg_wr_data;
		end
	end

	// range check on the incoming item; single-bit ops are a one-bit range
	logic             single_op;
	logic             range_op;
	logic [IDX_W-1:0] hi_eff;
	logic             range_bad;
	logic             err_d;

	always_comb begin
		single_op = (cmd_mode == MODE_WRITE_BIT) || (cmd_mode == MODE_READ_BIT);
		range_op  = single_op || (cmd_mode == MODE_RANGE_WRITE) ||
			(cmd_mode == MODE_RANGE_COUNT) || (cmd_mode == MODE_FIND_FIRST) ||
			(cmd_mode == MODE_FIND_LAST);
		hi_eff    = single_op ? cmd_low_index : cmd_high_index;
		range_bad = ({1'b0, hi_eff} >= bit_length_q) || (CAP_W'(hi_eff) >= CAP_BITS) ||
			(cmd_low_index > hi_eff);
		err_d     = range_op ? range_bad : (cmd_mode != MODE_CLEAR_ALL);
	end

	// item registers
	logic [MODE_W-1:0] mode_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic              val_q;
	logic              err_q;
	logic [WIDX_W-1:0] cur_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q <= cmd_mode;
			lo_q   <= cmd_low_index;
			hi_q   <= hi_eff;
			val_q  <= cmd_bit_in;
			err_q  <= err_d;
			cur_q  <= cmd_low_index[IDX_W-1:BIT_SEL_W];
		end else if (ctl.issue) begin
			cur_q  <= cur_q + 1'b1;
		end
	end

	// word store; a word whose flag is clear reads as zero
	logic [STORE_DEPTH-1:0] wvalid_q;
	logic                   ram_we;
	logic [WORD_W-1:0]      ram_wdata;
	logic [WORD_W-1:0]      ram_rdata;

	logic                   act_s1;
	logic                   act_s2;
	logic [WIDX_W-1:0]      w_s1;
	logic                   wvld_s1;
	logic [WIDX_W-1:0]      w_s2;
	logic [WORD_W-1:0]      sel_s2;

	bvre_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (w_s1[AW-1:0]),
		.wdata (ram_wdata),
		.re    (ctl.issue),
		.raddr (cur_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (ctl.load && cmd_mode == MODE_CLEAR_ALL) begin
			wvalid_q <= '0;
		end else if (ram_we) begin
			wvalid_q[w_s1[AW-1:0]] <= 1'b1;
		end
	end

	// stage 1: word data back from the store, mask the range, write back
	logic [WORD_W-1:0]    word_s1;
	logic [BIT_SEL_W-1:0] first_bit;
	logic [BIT_SEL_W-1:0] last_bit;
	logic [WORD_W-1:0]    mask_s1;

	always_comb begin
		word_s1   = wvld_s1 ? ram_rdata : '0;
		first_bit = (w_s1 == lo_q[IDX_W-1:BIT_SEL_W]) ? lo_q[BIT_SEL_W-1:0] : '0;
		last_bit  = (w_s1 == hi_q[IDX_W-1:BIT_SEL_W]) ? hi_q[BIT_SEL_W-1:0] : '1;
		mask_s1   = ({WORD_W{1'b1}} << first_bit) &
			({WORD_W{1'b1}} >> (BIT_SEL_W'(WORD_W - 1) - last_bit));
		ram_we    = act_s1 && ((mode_q == MODE_WRITE_BIT) || (mode_q == MODE_RANGE_WRITE));
		ram_wdata = val_q ? (word_s1 | mask_s1) : (word_s1 & ~mask_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= ctl.issue;
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			w_s1    <= cur_q;
			wvld_s1 <= wvalid_q[cur_q[AW-1:0]];
		end
		if (act_s1) begin
			w_s2   <= w_s1;
			sel_s2 <= word_s1 & mask_s1;
		end
	end

	// stage 2: count and search the selected bits
	logic [POP_W-1:0]     pop_s2;
	logic [BIT_SEL_W-1:0] low_bit_s2;
	logic [BIT_SEL_W-1:0] high_bit_s2;
	logic [WORD_W-1:0]    rev_s2;
	logic                 take_s2;

	always_comb begin
		pop_s2      = pop64(sel_s2);
		low_bit_s2  = onehot_idx(sel_s2 & (~sel_s2 + 1'b1));
		rev_s2      = rev64(sel_s2);
		high_bit_s2 = BIT_SEL_W'(WORD_W - 1) - onehot_idx(rev_s2 & (~rev_s2 + 1'b1));
	end

	logic [LEN_W-1:0] cnt_q;
	logic [IDX_W-1:0] pos_q;
	logic             found_q;

	// find first keeps the earliest hit, find last the latest
	assign take_s2 = act_s2 && (sel_s2 != '0) && ((mode_q == MODE_FIND_LAST) || !found_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (act_s2) begin
				cnt_q <= cnt_q + LEN_W'(pop_s2);
			end
			if (take_s2) begin
				found_q <= 1'b1;
				pos_q   <= {w_s2, (mode_q == MODE_FIND_LAST) ? high_bit_s2 : low_bit_s2};
			end
		end
	end

	// result register
	logic                    out_valid_q;
	logic                    bit_out_q;
	logic [LEN_W-1:0]        ones_count_q;
	logic signed [LEN_W-1:0] position_q;
	logic                    error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			bit_out_q    <= (mode_q == MODE_READ_BIT) && !err_q && (cnt_q != '0);
			ones_count_q <= ((mode_q == MODE_RANGE_COUNT) && !err_q) ? cnt_q : '0;
			if ((mode_q == MODE_FIND_FIRST) || (mode_q == MODE_FIND_LAST)) begin
				position_q <= found_q ? $signed({1'b0, pos_q}) : $signed(POS_NONE);
			end else begin
				position_q <= '0;
			end
			error_q      <= err_q;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_bit_out    = bit_out_q;
	assign rsp_ones_count = ones_count_q;
	assign rsp_position   = position_q;
	assign rsp_error      = error_q;

	assign sts.walk_needed = range_op && !range_bad;
	assign sts.last_word   = (cur_q == hi_q[IDX_W-1:BIT_SEL_W]);
	assign sts.pipe_busy   = act_s1 || act_s2;
	assign sts.out_free    = !out_valid_q || rsp_ready;

endmodule

// ----- rtl/bit_vector_range_engine.sv -----
// -----------------------------------------------------------------------------
// bit_vector_range_engine
// Bit vector of up to WORD_COUNT*64 bits with single-bit, range write, range
// count, find first/last and clear-all operations.
// -----------------------------------------------------------------------------
// One item at a time. An item is taken in the idle state, walks the stored
// words that its range spans (single-bit ops: one word), drains the pipe and
// then writes its result; an item that errors, clear all and the unused mode
// go straight from idle to the result. In the walk one 64-bit word is read
// from the store each cycle, with the write-back of the previous word on the
// separate write port, and passes a two-stage mask/write-back and count/search pipe.
// The store holds min(WORD_COUNT, 64) words, as 12-bit indices reach no
// further; per-word valid flags clear it at once on reset and clear all, so
// there is no clearing pass. A finished result sits in an output register, so
// the next item is taken while it waits.
// -----------------------------------------------------------------------------
module bit_vector_range_engine import bvre_pkg::*; #(
	parameter int WORD_COUNT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	bvre_cmd_if.sink         cmd,
	bvre_rsp_if.source       rsp
);

	ctrl_cmd_t ctl;
	ctrl_sts_t sts;

	bvre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	bvre_datapath #(
		.WORD_COUNT (WORD_COUNT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd_mode       (cmd.mode),
		.cmd_low_index  (cmd.low_index),
		.cmd_high_index (cmd.high_index),
		.cmd_bit_in     (cmd.bit_in),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_bit_out    (rsp.bit_out),
		.rsp_ones_count (rsp.ones_count),
		.rsp_position   (rsp.position),
		.rsp_error      (rsp.error),
		.ctl            (ctl),
		.sts            (sts)
	);

endmodule

// ----- rtl/bvre_checker.sv -----
// -----------------------------------------------------------------------------
// bvre_checker
// Port-level checks on the bit vector range engine, bound to the top level.
// -----------------------------------------------------------------------------
module bvre_checker import bvre_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cmd_valid,
	input logic                    cmd_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic                    rsp_bit_out,
	input logic [LEN_W-1:0]        rsp_ones_count,
	input logic signed [LEN_W-1:0] rsp_position,
	input logic                    rsp_error
);

	// result held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_bit_out) && $stable(rsp_ones_count) &&
			$stable(rsp_position) && $stable(rsp_error))
		else $error("stalled result changed");

	// one item at a time: busy straight after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("item taken while the previous one is in progress");

	// an error result carries no bit and no count
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_error |-> !rsp_bit_out && rsp_ones_count == '0)
		else $error("error result with data");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_ones_count <= LEN_RESET)
		else $error("count beyond vector size");

endmodule

bind bit_vector_range_engine bvre_checker u_bvre_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_bit_out    (rsp.bit_out),
	.rsp_ones_count (rsp.ones_count),
	.rsp_position   (rsp.position),
	.rsp_error      (rsp.error)
);

// ----- tb/sv/bvre_tb_pkg.sv -----
// -----------------------------------------------------------------------------
// bvre_tb_pkg
// Bit vector ledger for the range engine regression: keeps its own copy of the
// stored bits and the length in use, works out the reply to each accepted
// command item and checks the replies in order.
// -----------------------------------------------------------------------------
package bvre_tb_pkg;
	import bvre_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED  = 3'd7;
	localparam int unsigned       BIT_CAPACITY = MAX_WORDS * WORD_W;

	class bit_vector_ledger;
		typedef struct packed {
			logic             bit_out;
			logic [LEN_W-1:0] ones_count;
			logic [LEN_W-1:0] position;
			logic             error;
		} reply_t;

		bit [WORD_W-1:0] words [MAX_WORDS];
		int unsigned     length_setting;
		reply_t          expected_replies [$];
		int unsigned     mismatches;

		function new();
			clear_words();
			length_setting = LEN_RESET;
			mismatches = 0;
		endfunction

		function void clear_words();
			foreach (words[w]) words[w] = '0;
		endfunction

		function void set_length(logic [LEN_W-1:0] value);
			length_setting = value;
		endfunction

		function int unsigned pending();
			return expected_replies.size();
		endfunction

		// works out the reply of one accepted command item and updates the bits
		function void note_command(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] lo,
				logic [IDX_W-1:0] hi, logic value);
			reply_t      r;
			int unsigned limit;
			bit          cur;
			bit          found;
			limit = (length_setting < BIT_CAPACITY) ? length_setting : BIT_CAPACITY;
			r = '0;
			found = 1'b0;
			if (mode == MODE_FIND_FIRST || mode == MODE_FIND_LAST)
				r.position = POS_NONE;
			case (mode)
				MODE_WRITE_BIT, MODE_READ_BIT: begin
					if (lo >= limit)
						r.error = 1'b1;
					else if (mode == MODE_WRITE_BIT)
						words[lo >> BIT_SEL_W][lo[BIT_SEL_W-1:0]] = value;
					else
						r.bit_out = words[lo >> BIT_SEL_W][lo[BIT_SEL_W-1:0]];
				end
				MODE_RANGE_WRITE, MODE_RANGE_COUNT, MODE_FIND_FIRST, MODE_FIND_LAST: begin
					if (hi >= limit || lo > hi) begin
						r.error = 1'b1;
					end else begin
						for (int unsigned i = lo; i <= hi; i++) begin
							cur = words[i / WORD_W][i % WORD_W];
							case (mode)
								MODE_RANGE_WRITE: words[i / WORD_W][i % WORD_W] = value;
								MODE_RANGE_COUNT: if (cur) r.ones_count = r.ones_count + 1'b1;
								MODE_FIND_FIRST: begin
									if (cur && !found) begin
										r.position = LEN_W'(i);
										found = 1'b1;
									end
								end
								default: if (cur) r.position = LEN_W'(i);
							endcase
						end
					end
				end
				MODE_CLEAR_ALL: clear_words();
				default: r.error = 1'b1;
			endcase
			expected_replies.push_back(r);
		endfunction

		function void compare_field(string field, logic [LEN_W-1:0] want,
				logic [LEN_W-1:0] got, longint unsigned stamp);
			if (got !== want) begin
				$display("%0d ns: %s mismatch, expected %0h actual %0h", stamp, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic bit_out, logic [LEN_W-1:0] ones_count,
				logic [LEN_W-1:0] position, logic error, longint unsigned stamp);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0d ns: reply with no item outstanding, expected none actual %0h %0h %0h %0h",
					stamp, bit_out, ones_count, position, error);
				mismatches++;
				return;
			end
			want = expected_replies.pop_front();
			compare_field("bit_out", LEN_W'(want.bit_out), LEN_W'(bit_out), stamp);
			compare_field("ones_count", want.ones_count, ones_count, stamp);
			compare_field("position", want.position, position, stamp);
			compare_field("error", LEN_W'(want.error), LEN_W'(error), stamp);
		endfunction
	endclass

endpackage

// ----- tb/sv/bit_vector_range_engine_test.sv -----
// -----------------------------------------------------------------------------
// bit_vector_range_engine_test
// Regression for the bit vector range engine: a directed run over the edges of
// the index fields and every operation, then random commands under several
// lengths, with random idling on both channels and one long reply hold-off.
// -----------------------------------------------------------------------------
module bit_vector_range_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bvre_pkg::*;
	import bvre_tb_pkg::*;

	localparam int          STORE_WORDS     = 64;
	localparam int unsigned IDLE_LIMIT      = 5000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES   = 80;
	localparam int unsigned PHASE_COUNT     = 9;
	localparam int unsigned PHASE_LENGTH [PHASE_COUNT] =
		'{100, 1, 0, 8191, 64, 4095, 65, 2000, 4096};
	localparam int unsigned PHASE_ITEMS [PHASE_COUNT] =
		'{120, 50, 40, 150, 100, 150, 80, 150, 100};

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic              value;
	} command_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;

	bvre_cmd_if cmd_ch ();
	bvre_rsp_if rsp_ch ();

	bit_vector_ledger ledger = new;
	int unsigned      active_length = LEN_RESET;
	int unsigned      send_stall_pct = 0;
	int unsigned      quiet_cycles = 0;
	bit               quiet_tail = 1'b0;
	bit               hold_off_req = 1'b0;

	bit_vector_range_engine #(
		.WORD_COUNT(STORE_WORDS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready)
			ledger.note_command(cmd_ch.mode, cmd_ch.low_index, cmd_ch.high_index, cmd_ch.bit_in);
		if (rsp_ch.valid && rsp_ch.ready)
			ledger.check_result(rsp_ch.bit_out, rsp_ch.ones_count, rsp_ch.position,
				rsp_ch.error, $time);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("bit_vector_range_engine regression: fail");
			$finish;
		end
	end

	// reply side: random stall bursts, one long hold-off on request
	initial begin
		int unsigned take_stall_pct;
		int unsigned stretch_left;
		take_stall_pct = 0;
		stretch_left = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stretch_left == 0) begin
				case ($urandom_range(0, 3))
					0: take_stall_pct = 0;
					1: take_stall_pct = 5;
					2: take_stall_pct = 20;
					default: take_stall_pct = 50;
				endcase
				stretch_left = 256;
			end
			stretch_left--;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 99) < take_stall_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic command_t random_command(int unsigned length);
		command_t    c;
		int unsigned pick;
		int unsigned span;
		int unsigned limit;
		limit = (length < BIT_CAPACITY) ? length : BIT_CAPACITY;
		pick = $urandom_range(0, 99);
		if (pick < 15)      c.mode = MODE_WRITE_BIT;
		else if (pick < 30) c.mode = MODE_READ_BIT;
		else if (pick < 47) c.mode = MODE_RANGE_WRITE;
		else if (pick < 63) c.mode = MODE_RANGE_COUNT;
		else if (pick < 79) c.mode = MODE_FIND_FIRST;
		else if (pick < 95) c.mode = MODE_FIND_LAST;
		else if (pick < 98) c.mode = MODE_CLEAR_ALL;
		else                c.mode = MODE_UNUSED;
		c.value = 1'($urandom_range(0, 1));
		c.lo = IDX_W'($urandom_range(0, 4095));
		c.hi = IDX_W'($urandom_range(0, 4095));
		pick = $urandom_range(0, 99);
		if (limit != 0 && pick < 85) begin
			c.lo = IDX_W'($urandom_range(0, limit - 1));
			if (pick < 8) begin
				c.lo = '0;
				c.hi = IDX_W'(limit - 1);
			end else begin
				// mostly short spans, now and then a long one
				span = (pick < 20) ? $urandom_range(0, limit - 1) : $urandom_range(0, 130);
				c.hi = IDX_W'((c.lo + span < limit) ? c.lo + span : limit - 1);
			end
		end else if (pick < 92 && c.lo < c.hi) begin
			{c.lo, c.hi} = {c.hi, c.lo};
		end
		return c;
	endfunction

	task automatic send_command(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] lo,
			input logic [IDX_W-1:0] hi, input logic value);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.mode       <= mode;
		cmd_ch.low_index  <= lo;
		cmd_ch.high_index <= hi;
		cmd_ch.bit_in     <= value;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic offer_command(input command_t c);
		if (!quiet_tail && $urandom_range(0, 99) < send_stall_pct) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		send_command(c.mode, c.lo, c.hi, c.value);
	endtask

	task automatic run_random(input int count, input int pressure_at);
		for (int k = 0; k < count; k++) begin
			if (k % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: send_stall_pct = 0;
					1: send_stall_pct = 5;
					2: send_stall_pct = 20;
					default: send_stall_pct = 50;
				endcase
			end
			if (k == pressure_at)
				hold_off_req = 1'b1;
			offer_command(random_command(active_length));
		end
		cmd_ch.valid <= 1'b0;
	endtask

	// let the last accepted item be noted, then wait for every reply
	task automatic drain_results();
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_length(input logic [LEN_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ledger.set_length(value);
		active_length = value;
		@(posedge clk);
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.mode       <= MODE_WRITE_BIT;
		cmd_ch.low_index  <= '0;
		cmd_ch.high_index <= '0;
		cmd_ch.bit_in     <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full length: empty vector, the two end bits, word boundaries
		send_command(MODE_FIND_FIRST, 12'd0, 12'd4095, 1'b0);
		send_command(MODE_RANGE_COUNT, 12'd0, 12'd4095, 1'b0);
		send_command(MODE_WRITE_BIT, 12'd0, 12'd0, 1'b1);
		send_command(MODE_WRITE_BIT, 12'd4095, 12'd0, 1'b1);
		send_command(MODE_READ_BIT, 12'd4095, 12'd0, 1'b0);
		send_command(MODE_READ_BIT, 12'd0, 12'd0, 1'b0);
		send_command(MODE_FIND_FIRST, 12'd0, 12'd4095, 1'b0);
		send_command(MODE_FIND_LAST, 12'd0, 12'd4095, 1'b0);
		send_command(MODE_RANGE_WRITE, 12'd1, 12'd4094, 1'b1);
		send_command(MODE_RANGE_COUNT, 12'd0, 12'd4095, 1'b0);
		send_command(MODE_RANGE_WRITE, 12'd63, 12'd64, 1'b0);
		send_command(MODE_FIND_FIRST, 12'd63, 12'd64, 1'b0);
		send_command(MODE_FIND_LAST, 12'd0, 12'd64, 1'b0);
		send_command(MODE_RANGE_COUNT, 12'd60, 12'd70, 1'b0);
		send_command(MODE_RANGE_COUNT, 12'd10, 12'd9, 1'b0);
		send_command(MODE_UNUSED, 12'd0, 12'd0, 1'b0);
		send_command(MODE_CLEAR_ALL, 12'd4095, 12'd4095, 1'b1);
		send_command(MODE_FIND_LAST, 12'd0, 12'd4095, 1'b0);
		send_command(MODE_READ_BIT, 12'd4095, 12'd0, 1'b0);
		send_command(MODE_RANGE_WRITE, 12'd5, 12'd5, 1'b1);
		send_command(MODE_FIND_FIRST, 12'd5, 12'd5, 1'b0);
		cmd_ch.valid <= 1'b0;
		drain_results();

		run_random(300, 120);
		drain_results();

		// short length: indices just past the end
		set_length(13'd100);
		send_command(MODE_READ_BIT, 12'd100, 12'd0, 1'b0);
		send_command(MODE_FIND_FIRST, 12'd0, 12'd100, 1'b0);
		send_command(MODE_WRITE_BIT, 12'd99, 12'd0, 1'b1);
		send_command(MODE_FIND_LAST, 12'd99, 12'd99, 1'b0);
		cmd_ch.valid <= 1'b0;
		drain_results();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_length(LEN_W'(PHASE_LENGTH[p]));
			run_random(PHASE_ITEMS[p], -1);
			drain_results();
		end

		quiet_tail = 1'b1;
		set_length(LEN_W'($urandom_range(1, 4096)));
		run_random(160, -1);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0)
			$display("bit_vector_range_engine regression: pass");
		else
			$display("bit_vector_range_engine regression: fail");
		$finish;
	end

endmodule
